// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int OW = OPERAND_WIDTH;
	localparam int PW = 2 * OW;          // product width
	localparam int VW = PW + 2;          // signed value width (sums of products)
	localparam int MW = VW;              // magnitude width
	localparam int OUT_W = 33;
	localparam int DIV_CW = $clog2(MW + 1);

	localparam logic [3:0] MODE_ADD = 4'd0;
	localparam logic [3:0] MODE_SUB = 4'd1;
	localparam logic [3:0] MODE_MUL = 4'd2;
	localparam logic [3:0] MODE_DIV = 4'd3;
	localparam logic [3:0] MODE_INC = 4'd4;
	localparam logic [3:0] MODE_DEC = 4'd5;
	localparam logic [3:0] MODE_EQ  = 4'd6;
	localparam logic [3:0] MODE_NE  = 4'd7;
	localparam logic [3:0] MODE_LT  = 4'd8;
	localparam logic [3:0] MODE_GT  = 4'd9;
	localparam logic [3:0] MODE_LE  = 4'd10;
	localparam logic [3:0] MODE_GE  = 4'd11;

	typedef struct packed {
		logic load;      // capture operands, form the products
		logic combine;   // form numerator and denominator
		logic gcd_init;  // prepare gcd operands
		logic gcd_step;  // one gcd iteration
		logic div_init;  // start divisions by the gcd
		logic div_step;  // one restoring division bit
		logic finish;    // build the result into the output register
	} rau_cmd_t;

	typedef struct packed {
		logic skip_reduce; // compare mode, unused mode or a zero term
		logic gcd_done;
		logic div_done;
	} rau_sts_t;

endpackage

// ===== rtl/core/rau_if.sv =====
interface rau_in_if;
	import rau_pkg::*;
	logic valid;
	logic ready;
	logic [3:0] mode;
	logic signed [15:0] a_num;
	logic signed [15:0] a_den;
	logic signed [15:0] b_num;
	logic signed [15:0] b_den;
	modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic valid;
	logic ready;
	logic signed [32:0] res_num;
	logic signed [32:0] res_den;
	logic cmp_true;
	modport source (output valid, res_num, res_den, cmp_true, input ready);
	modport sink (input valid, res_num, res_den, cmp_true, output ready);
endinterface

// ===== rtl/core/rau_datapath.sv =====
module rau_datapath
	import rau_pkg::*;
(
	input  logic clk,
	input  rau_cmd_t cmd,
	output rau_sts_t sts,
	input  logic [3:0] mode,
	input  logic [15:0] a_num,
	input  logic [15:0] a_den,
	input  logic [15:0] b_num,
	input  logic [15:0] b_den,
	output logic signed [32:0] res_num,
	output logic signed [32:0] res_den,
	output logic cmp_true
);

	function automatic logic signed [OW-1:0] opnd(input logic [15:0] raw);
		logic [OW-1:0] v;
		v = OW'({{(OW > 16 ? OW - 16 : 1){1'b0}}, raw});
		return $signed(v);
	endfunction

	logic [3:0] mode_q;
	logic signed [OW-1:0] an_q, ad_q;
	logic signed [PW-1:0] left_q, right_q, nn_q, dd_q, nd_q, dn_q;
	logic signed [VW-1:0] n_q, d_q;
	logic [MW-1:0] gx_q, gy_q;
	logic [DIV_CW-1:0] k_q, cnt_q;
	logic [MW-1:0] qn_q, qd_q, rn_q, rd_q;
	logic reduce_q;
	logic signed [OUT_W-1:0] rnum_q, rden_q;
	logic flag_q;

	logic signed [VW-1:0] n_c, d_c;
	logic [MW-1:0] mn, md, y_sh, sx, sy, rn_sh, rd_sh;
	logic [MW:0] rn_t, rd_t;
	logic [MW-1:0] g;
	logic arith;
	logic fl;

	always_comb begin
		arith = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) || (mode_q == MODE_MUL) ||
			(mode_q == MODE_DIV) || (mode_q == MODE_INC) || (mode_q == MODE_DEC);
		unique case (mode_q)
			MODE_ADD: begin n_c = VW'(left_q) + VW'(right_q); d_c = VW'(dd_q); end
			MODE_SUB: begin n_c = VW'(left_q) - VW'(right_q); d_c = VW'(dd_q); end
			MODE_MUL: begin n_c = VW'(nn_q); d_c = VW'(dd_q); end
			MODE_DIV: begin n_c = VW'(nd_q); d_c = VW'(dn_q); end
			MODE_INC: begin n_c = VW'(an_q) + VW'(ad_q); d_c = VW'(ad_q); end
			MODE_DEC: begin n_c = VW'(an_q) - VW'(ad_q); d_c = VW'(ad_q); end
			default:  begin n_c = '0; d_c = '0; end
		endcase
		mn = n_q[VW-1] ? MW'(-n_q) : MW'(n_q);
		md = d_q[VW-1] ? MW'(-d_q) : MW'(d_q);
		y_sh = gy_q[0] ? gy_q : (gy_q >> 1);
		sx = (gx_q > y_sh) ? y_sh : gx_q;
		sy = (gx_q > y_sh) ? gx_q : y_sh;
		g = gx_q << k_q;
		rn_sh = rn_q;
		rd_sh = rd_q;
		rn_t = {rn_sh, qn_q[MW-1]} - {1'b0, g};
		rd_t = {rd_sh, qd_q[MW-1]} - {1'b0, g};
		unique case (mode_q)
			MODE_EQ: fl = (left_q == right_q);
			MODE_NE: fl = (left_q != right_q);
			MODE_LT: fl = (left_q < right_q);
			MODE_GT: fl = (left_q > right_q);
			MODE_LE: fl = (left_q <= right_q);
			MODE_GE: fl = (left_q >= right_q);
			default: fl = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			an_q    <= opnd(a_num);
			ad_q    <= opnd(a_den);
			left_q  <= opnd(a_num) * opnd(b_den);
			right_q <= opnd(b_num) * opnd(a_den);
			nn_q    <= opnd(a_num) * opnd(b_num);
			dd_q    <= opnd(a_den) * opnd(b_den);
			nd_q    <= opnd(a_num) * opnd(b_den);
			dn_q    <= opnd(a_den) * opnd(b_num);
		end
		if (cmd.combine) begin
			n_q <= n_c;
			d_q <= d_c;
			reduce_q <= arith && (n_c != '0) && (d_c != '0);
			flag_q <= fl;
		end
		if (cmd.gcd_init) begin
			// strip common twos first: counted in k
			gx_q <= mn;
			gy_q <= md;
			k_q  <= '0;
		end
		if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				k_q  <= k_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else begin
				gx_q <= sx;
				gy_q <= sy - sx;
			end
		end
		if (cmd.div_init) begin
			qn_q <= mn;
			qd_q <= md;
			rn_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (!rn_t[MW]) begin
				rn_q <= rn_t[MW-1:0];
				qn_q <= {qn_q[MW-2:0], 1'b1};
			end else begin
				rn_q <= {rn_q[MW-2:0], qn_q[MW-1]};
				qn_q <= {qn_q[MW-2:0], 1'b0};
			end
			if (!rd_t[MW]) begin
				rd_q <= rd_t[MW-1:0];
				qd_q <= {qd_q[MW-2:0], 1'b1};
			end else begin
				rd_q <= {rd_q[MW-2:0], qd_q[MW-1]};
				qd_q <= {qd_q[MW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (!arith) begin
				rnum_q <= '0;
				rden_q <= '0;
			end else if (!reduce_q) begin
				rnum_q <= OUT_W'(n_q);
				rden_q <= OUT_W'(d_q);
			end else begin
				rnum_q <= n_q[VW-1] ? OUT_W'(-qn_q) : OUT_W'(qn_q);
				rden_q <= d_q[VW-1] ? OUT_W'(-qd_q) : OUT_W'(qd_q);
			end
			cmp_true <= arith ? 1'b0 : flag_q;
		end
	end

	assign sts.skip_reduce = !reduce_q;
	assign sts.gcd_done = (gy_q == '0) || (gx_q[0] && (y_sh == gx_q));
	assign sts.div_done = (cnt_q == DIV_CW'(MW - 1));
	assign res_num = rnum_q;
	assign res_den = rden_q;

endmodule

// ===== rtl/core/rau_ctrl.sv =====
module rau_ctrl
	import rau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output rau_cmd_t cmd,
	input  rau_sts_t sts
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_COMBINE = 3'd1;
	localparam logic [2:0] ST_DECIDE  = 3'd2;
	localparam logic [2:0] ST_GCD     = 3'd3;
	localparam logic [2:0] ST_DIV     = 3'd4;
	localparam logic [2:0] ST_FINISH  = 3'd5;

	logic [2:0] state_q, state_d;
	logic out_valid_q;

	// the output register frees once its result is taken
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				cmd.load = 1'b1;
				state_d = ST_COMBINE;
			end
			ST_COMBINE: begin
				cmd.combine = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.gcd_init = 1'b1;
				state_d = sts.skip_reduce ? ST_FINISH : ST_GCD;
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_FINISH;
			end
			ST_FINISH: if (!out_valid_q || out_ready) begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Compares and unreduced results pass through load, combine, decide and finish.
// Reduced results pass through load, combine, decide, the binary gcd steps, the start of the division,
// 34 restoring division steps and finish.
// GCD steps: one per shift or subtract.
// Only one item is in flight: a new one is taken in idle, once the output register is free.
// Reset: arst_n low clears the controller to idle and drops the output valid at once.
module rational_arithmetic_unit
	import rau_pkg::*;
(
	input logic clk,
	input logic arst_n,
	rau_in_if.sink in_ch,
	rau_out_if.source out_ch
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	// controller: sequences load, combine, gcd and division, then drives the result transfer
	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	// datapath: products, binary gcd and shared-step division of both terms
	rau_datapath u_dp (
		.clk(clk), .cmd(cmd), .sts(sts),
		.mode(in_ch.mode), .a_num(in_ch.a_num), .a_den(in_ch.a_den),
		.b_num(in_ch.b_num), .b_den(in_ch.b_den),
		.res_num(out_ch.res_num), .res_den(out_ch.res_den), .cmp_true(out_ch.cmp_true)
	);

endmodule

// ===== verif/rational_arithmetic_unit_tb.sv =====
module rational_arithmetic_unit_tb;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [3:0]         mode;
		logic signed [15:0] a_num;
		logic signed [15:0] a_den;
		logic signed [15:0] b_num;
		logic signed [15:0] b_den;
	} operands_t;

	typedef struct {
		logic signed [32:0] num;
		logic signed [32:0] den;
		logic               flag;
	} fraction_t;

	// one row of the directed table; known marks a result typed in by hand
	typedef struct {
		operands_t op;
		bit        known;
		fraction_t res;
	} vector_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   sent;
	int   received;
	int   reduced_seen;
	bit   stim_done;

	fraction_t pending_q[$];
	vector_t   vectors[$];

	rau_in_if  in_ch();
	rau_out_if out_ch();

	rational_arithmetic_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Binary gcd over magnitudes; a zero operand yields the other one.
	function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
		int k;
		longint unsigned t;
		k = 0;
		if (x == 0) return y;
		if (y == 0) return x;
		while (((x | y) & 1) == 0) begin
			x >>= 1;
			y >>= 1;
			k++;
		end
		while ((x & 1) == 0) x >>= 1;
		while (y != 0) begin
			while ((y & 1) == 0) y >>= 1;
			if (x > y) begin
				t = x;
				x = y;
				y = t;
			end
			y -= x;
		end
		return x << k;
	endfunction

	// Work out the result of one fraction operation at 64 bits, then
	// truncate to the 33-bit result fields.
	function automatic fraction_t rational_result(operands_t op);
		longint an, ad, bn, bd, n, d, lhs, rhs;
		longint unsigned g;
		bit arith;
		fraction_t r;
		an = op.a_num;
		ad = op.a_den;
		bn = op.b_num;
		bd = op.b_den;
		lhs = an * bd;
		rhs = bn * ad;
		n = 0;
		d = 0;
		arith = 1'b1;
		r.flag = 1'b0;
		case (op.mode)
			MODE_ADD: begin n = lhs + rhs; d = ad * bd; end
			MODE_SUB: begin n = lhs - rhs; d = ad * bd; end
			MODE_MUL: begin n = an * bn; d = ad * bd; end
			MODE_DIV: begin n = an * bd; d = ad * bn; end
			MODE_INC: begin n = an + ad; d = ad; end
			MODE_DEC: begin n = an - ad; d = ad; end
			MODE_EQ: begin arith = 1'b0; r.flag = lhs == rhs; end
			MODE_NE: begin arith = 1'b0; r.flag = lhs != rhs; end
			MODE_LT: begin arith = 1'b0; r.flag = lhs < rhs; end
			MODE_GT: begin arith = 1'b0; r.flag = lhs > rhs; end
			MODE_LE: begin arith = 1'b0; r.flag = lhs <= rhs; end
			MODE_GE: begin arith = 1'b0; r.flag = lhs >= rhs; end
			default: arith = 1'b0;
		endcase
		// leave a zero term unreduced; the denominator sign is kept as is
		if (arith && n != 0 && d != 0) begin
			g = gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d);
			if (g > 1) begin
				n = n / longint'(g);
				d = d / longint'(g);
			end
		end
		r.num = arith ? n[32:0] : '0;
		r.den = arith ? d[32:0] : '0;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3, 4: return 16'($signed($urandom_range(0, 24)) - 12);
			5, 6: return 16'($signed($urandom_range(0, 600)) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic vector_t row(logic [3:0] m, int an, int ad, int bn, int bd,
			bit known = 0, longint rn = 0, longint rd = 0, bit rf = 0);
		vector_t v;
		v.op.mode = m;
		v.op.a_num = 16'(an);
		v.op.a_den = 16'(ad);
		v.op.b_num = 16'(bn);
		v.op.b_den = 16'(bd);
		v.known = known;
		v.res.num = 33'(rn);
		v.res.den = 33'(rd);
		v.res.flag = rf;
		return v;
	endfunction

	// Drop valid only when a real gap follows, so back-to-back sends keep it high.
	task automatic idle_gap(int long_pct);
		int n;
		if ($urandom_range(0, 99) < long_pct) n = $urandom_range(10, 120);
		else if ($urandom_range(0, 2) == 0) n = 0;
		else n = $urandom_range(1, 4);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one operand set and hold it until the transfer.
	task automatic send(operands_t op, fraction_t res);
		in_ch.valid <= 1'b1;
		in_ch.mode  <= op.mode;
		in_ch.a_num <= op.a_num;
		in_ch.a_den <= op.a_den;
		in_ch.b_num <= op.b_num;
		in_ch.b_den <= op.b_den;
		pending_q.push_back(res);
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	// Stimulus: directed table first, then random operand sets.
	initial begin
		operands_t op;
		fraction_t exp_res;
		bit burst;
		in_ch.valid <= 1'b0;
		in_ch.mode  <= MODE_ADD;
		in_ch.a_num <= '0;
		in_ch.a_den <= '0;
		in_ch.b_num <= '0;
		in_ch.b_den <= '0;
		arst_n = 1'b0;
		errors = 0;
		sent = 0;
		stim_done = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		vectors.push_back(row(MODE_ADD, 1, 2, 1, 3, 1, 5, 6));
		vectors.push_back(row(MODE_SUB, 1, 2, 1, 2, 1, 0, 4));
		vectors.push_back(row(MODE_MUL, 2, 3, 3, 4, 1, 1, 2));
		vectors.push_back(row(MODE_DIV, 1, 2, 1, 4, 1, 2, 1));
		vectors.push_back(row(MODE_INC, 3, 4, 0, 0, 1, 7, 4));
		vectors.push_back(row(MODE_DEC, 3, 4, 0, 0, 1, -1, 4));
		vectors.push_back(row(MODE_EQ, 1, 2, 2, 4, 1, 0, 0, 1));
		vectors.push_back(row(MODE_NE, 1, 2, 2, 4, 1, 0, 0, 0));
		vectors.push_back(row(MODE_LT, 1, 3, 1, 2, 1, 0, 0, 1));
		vectors.push_back(row(MODE_GT, 1, 3, 1, 2, 1, 0, 0, 0));
		vectors.push_back(row(MODE_LE, 1, 2, 1, 2, 1, 0, 0, 1));
		vectors.push_back(row(MODE_GE, 1, 3, 1, 2, 1, 0, 0, 0));
		// negative denominator survives reduction
		vectors.push_back(row(MODE_MUL, 2, -4, 1, 1, 1, 1, -2));
		// zero denominator passes straight through
		vectors.push_back(row(MODE_INC, 6, 0, 0, 0, 1, 6, 0));
		// divide by a zero fraction
		vectors.push_back(row(MODE_DIV, 4, 6, 0, 2, 1, 8, 0));
		// unused modes give all zero
		vectors.push_back(row(4'd12, 5, 7, 3, 9, 1, 0, 0, 0));
		vectors.push_back(row(4'd15, -1, -1, -1, -1, 1, 0, 0, 0));
		// extremes
		vectors.push_back(row(MODE_MUL, -32768, -32768, -32768, -32768, 1, 1, 1));
		vectors.push_back(row(MODE_ADD, -32768, 32767, -32768, 32767));
		vectors.push_back(row(MODE_SUB, 32767, -32768, -32768, 32767));
		vectors.push_back(row(MODE_DIV, -32768, 32767, 32767, -32768));
		vectors.push_back(row(MODE_DEC, -32768, 32767, 0, 0));
		vectors.push_back(row(MODE_LT, -32768, -1, 32767, 1));
		vectors.push_back(row(MODE_GE, 32767, -32768, -32768, -32768));
		vectors.push_back(row(MODE_EQ, 0, 0, 0, 0, 1, 0, 0, 1));

		foreach (vectors[i]) begin
			exp_res = vectors[i].known ? vectors[i].res : rational_result(vectors[i].op);
			send(vectors[i].op, exp_res);
			idle_gap(5);
		end

		burst = 0;
		repeat (1950) begin
			op.mode  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
				: 4'($urandom_range(0, 11));
			op.a_num = rand_operand();
			op.a_den = rand_operand();
			op.b_num = rand_operand();
			op.b_den = rand_operand();
			send(op, rational_result(op));
			if ($urandom_range(0, 49) == 0) burst = !burst;
			if (!burst) idle_gap(4);
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// Result side: random back-pressure, bursts of steady acceptance.
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if ($urandom_range(0, 3) != 0) begin
				out_ch.ready <= 1'b0;
				if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 150)) @(posedge clk);
				else repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	end

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		fraction_t exp_res;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			received++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d flag=%0b", $time,
					out_ch.res_num, out_ch.res_den, out_ch.cmp_true);
				errors++;
			end else begin
				exp_res = pending_q.pop_front();
				if (exp_res.den != 0 && exp_res.num != 0) reduced_seen++;
				if (out_ch.res_num !== exp_res.num) begin
					$display("%0t: res_num expected %0d actual %0d", $time,
						exp_res.num, out_ch.res_num);
					errors++;
				end
				if (out_ch.res_den !== exp_res.den) begin
					$display("%0t: res_den expected %0d actual %0d", $time,
						exp_res.den, out_ch.res_den);
					errors++;
				end
				if (out_ch.cmp_true !== exp_res.flag) begin
					$display("%0t: cmp_true expected %0b actual %0b", $time,
						exp_res.flag, out_ch.cmp_true);
					errors++;
				end
			end
		end
	end

	// Drain, wait for stray results, then report.
	initial begin
		wait (stim_done);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d operand sets, checked %0d results (%0d non-zero fractions).",
			sent, received, reduced_seen);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: ~2000 items must drain before the timeout, even with the longest stalls.
	initial begin
		#10ms;
		$display("Timeout with %0d results outstanding", pending_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
